// File: rtl/blfb_pkg.sv
package blfb_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 84;
  localparam int unsigned SCREEN_HEIGHT_DEF = 48;
  localparam int unsigned BAND_ROWS         = 8;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 9;
  // Bresenham decision term, signed
  localparam int unsigned DEC_W   = 12;
  // wide enough for any store address at the largest screen
  localparam int unsigned WADDR_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the accepted command
    logic setup;     // initialize the line walker
    logic step;      // advance the walker by one pixel
    logic pix_wr;    // write back the ORed pixel byte and count it
    logic clr_wr;    // write zero at the clear pointer
    logic rd_sel;    // read port addressed by the read index
    logic rd_cap;    // capture read data as the result byte
    logic rsp_push;  // move the result into the output register
  } blfb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            in_bounds;
    logic            last_step;
    logic            clr_last;
    logic            idx_ok;
    logic            rsp_free;
  } blfb_sts_t;

endpackage

// File: rtl/blfb_if.sv
interface blfb_cmd_if;
  import blfb_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [IDX_W-1:0]   read_index;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, read_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, read_index,
    output ready
  );
endinterface

interface blfb_rsp_if;
  import blfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  pixels_written;

  modport source (
    output valid, read_byte, pixels_written,
    input  ready
  );
  modport sink (
    input  valid, read_byte, pixels_written,
    output ready
  );
endinterface

// File: rtl/blfb_ram.sv
module blfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 504
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/blfb_ctrl.sv
module blfb_ctrl
  import blfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  blfb_sts_t sts_i,
  output blfb_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_CAP,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.opcode)
          OP_DRAW: begin
            cmd_o.setup = 1'b1;
            state_d     = ST_PIX_RD;
          end
          OP_READ: begin
            cmd_o.rd_sel = 1'b1;
            state_d      = sts_i.idx_ok ? ST_RD_CAP : ST_RESP;
          end
          OP_CLEAR: state_d = ST_CLEAR;
          default:  state_d = ST_RESP;
        endcase
      end
      ST_PIX_RD: begin
        // off-screen pixels are walked over without a memory access
        if (sts_i.in_bounds) begin
          state_d = ST_PIX_WR;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last_step) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        cmd_o.step   = 1'b1;
        state_d      = sts_i.last_step ? ST_RESP : ST_PIX_RD;
      end
      ST_RD_CAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = ST_RESP;
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.rsp_free) begin
          cmd_o.rsp_push = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/blfb_dp.sv
module blfb_dp
  import blfb_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  blfb_cmd_t    cmd_i,
  output blfb_sts_t    sts_o,
  blfb_cmd_if.sink     cmd_i_if,
  blfb_rsp_if.source   rsp_o_if
);

  localparam int unsigned BAND_COUNT  = (SCREEN_HEIGHT + BAND_ROWS - 1) / BAND_ROWS;
  localparam int unsigned STORE_DEPTH = BAND_COUNT * SCREEN_WIDTH;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  // captured command
  logic [OP_W-1:0]    opcode_q;
  logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [IDX_W-1:0]   idx_q;

  // line walker
  logic                    steep_q, neg_q;
  logic [COORD_W-1:0]      ma_q, mi_q, left_q;
  logic signed [DEC_W-1:0] d_q, inc_q, dec_q;

  logic [BYTE_W-1:0] byte_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [AW-1:0]     clr_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // setup terms
  logic [COORD_W-1:0]      adx, ady, a0, a1, n0, n1, dma, admi;
  logic                    steep, swap, neg;
  logic signed [DEC_W-1:0] d0, inc0, dec0;

  always_comb begin
    adx   = (sx_q > ex_q) ? sx_q - ex_q : ex_q - sx_q;
    ady   = (sy_q > ey_q) ? sy_q - ey_q : ey_q - sy_q;
    steep = !(ady < adx);
    swap  = steep ? (sy_q > ey_q) : (sx_q > ex_q);
    if (steep) begin
      a0 = swap ? ey_q : sy_q;
      a1 = swap ? sy_q : ey_q;
      n0 = swap ? ex_q : sx_q;
      n1 = swap ? sx_q : ex_q;
    end else begin
      a0 = swap ? ex_q : sx_q;
      a1 = swap ? sx_q : ex_q;
      n0 = swap ? ey_q : sy_q;
      n1 = swap ? sy_q : ey_q;
    end
    dma  = a1 - a0;
    neg  = n1 < n0;
    admi = neg ? n0 - n1 : n1 - n0;
    inc0 = $signed({{(DEC_W-COORD_W-1){1'b0}}, admi, 1'b0});
    d0   = inc0 - $signed({{(DEC_W-COORD_W){1'b0}}, dma});
    dec0 = inc0 - $signed({{(DEC_W-COORD_W-1){1'b0}}, dma, 1'b0});
  end

  // current pixel
  logic [COORD_W-1:0]  px, py;
  logic [WADDR_W-1:0]  pix_wide, idx_wide;
  logic [AW-1:0]       pix_addr;
  logic [BYTE_W-1:0]   pix_mask;

  always_comb begin
    px       = steep_q ? mi_q : ma_q;
    py       = steep_q ? ma_q : mi_q;
    pix_wide = WADDR_W'(py >> $clog2(BAND_ROWS)) * WADDR_W'(SCREEN_WIDTH) + WADDR_W'(px);
    pix_addr = pix_wide[AW-1:0];
    pix_mask = BYTE_W'(1) << py[$clog2(BAND_ROWS)-1:0];
    idx_wide = WADDR_W'(idx_q);
  end

  // memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  always_comb begin
    mem_we    = cmd_i.clr_wr || cmd_i.pix_wr;
    mem_waddr = cmd_i.clr_wr ? clr_q : pix_addr;
    mem_wdata = cmd_i.clr_wr ? '0 : (mem_rdata | pix_mask);
    mem_raddr = cmd_i.rd_sel ? idx_wide[AW-1:0] : pix_addr;
  end

  blfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q <= cmd_i_if.opcode;
      sx_q     <= cmd_i_if.start_x;
      sy_q     <= cmd_i_if.start_y;
      ex_q     <= cmd_i_if.end_x;
      ey_q     <= cmd_i_if.end_y;
      idx_q    <= cmd_i_if.read_index;
      byte_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.rd_cap) begin
        byte_q <= mem_rdata;
      end
      if (cmd_i.pix_wr) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.setup) begin
      steep_q <= steep;
      neg_q   <= neg;
      ma_q    <= a0;
      mi_q    <= n0;
      left_q  <= dma;
      d_q     <= d0;
      inc_q   <= inc0;
      dec_q   <= dec0;
    end else if (cmd_i.step) begin
      ma_q   <= ma_q + COORD_W'(1);
      left_q <= left_q - COORD_W'(1);
      if (!d_q[DEC_W-1] && (d_q != '0)) begin
        mi_q <= neg_q ? mi_q - COORD_W'(1) : mi_q + COORD_W'(1);
        d_q  <= d_q + dec_q;
      end else begin
        d_q <= d_q + inc_q;
      end
    end
    if (cmd_i.rsp_push) begin
      out_byte_q <= byte_q;
      out_cnt_q  <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= (clr_q == AW'(STORE_DEPTH - 1)) ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.rsp_push) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.opcode    = opcode_q;
  assign sts_o.in_bounds = (WADDR_W'(px) < WADDR_W'(SCREEN_WIDTH)) &&
                           (WADDR_W'(py) < WADDR_W'(SCREEN_HEIGHT));
  assign sts_o.last_step = (left_q == '0);
  assign sts_o.clr_last  = (clr_q == AW'(STORE_DEPTH - 1));
  assign sts_o.idx_ok    = (idx_wide < WADDR_W'(STORE_DEPTH));
  assign sts_o.rsp_free  = !out_valid_q || rsp_o_if.ready;

  assign rsp_o_if.valid          = out_valid_q;
  assign rsp_o_if.read_byte      = out_byte_q;
  assign rsp_o_if.pixels_written = out_cnt_q;

endmodule

// File: rtl/bresenham_line_frame_buffer_core.sv
// Line-drawing engine with a vertical-byte monochrome frame buffer.
// cmd_i carries one command per transfer: draw a line (opcode 0), read one
// buffer byte at read_index (opcode 1) or clear the buffer (opcode 2).
// rsp_o returns exactly one result per command, in command order:
// read_byte for reads, pixels_written for draws, zeros otherwise.
// Commands are processed one at a time. A draw visits every pixel of the
// line; an on-screen pixel is a read-modify-write of the buffer (registered
// read, then an ORed write-back), and an off-screen pixel skips the write.
// A read past the end of the buffer returns zero, and a clear writes all
// STORE_DEPTH bytes (504 at 84x48).
// The result sits in an output register; cmd_i is ready again as soon as it
// is loaded, so the next command runs while a stalled result waits. If the
// receiver still holds the earlier result, a finished command waits for it.
// After reset the buffer is zeroed by a clearing pass over all STORE_DEPTH
// bytes (504 at 84x48), during which cmd_i.ready stays low.
module bresenham_line_frame_buffer_core
  import blfb_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blfb_cmd_if.sink   cmd_i,
  blfb_rsp_if.source rsp_o
);

  blfb_cmd_t cmd;
  blfb_sts_t sts;

  blfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .cmd_i_if (cmd_i),
    .rsp_o_if (rsp_o)
  );

endmodule
